// ----- sv/dnsar_pkg.sv -----
// Package with shared types and constants for the DNS response A-record parser.
package dnsar_pkg;

	// One packet byte with its end-of-packet marker.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// One parse result, emitted on the last byte of a packet.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
	} out_item_t;

	// Result status codes.
	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_NO_A     = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	// Register index of the transaction id register.
	localparam logic REG_EXPECTED_ID = 1'b0;

	// Protocol constants.
	localparam int unsigned HDR_BYTES   = 12;
	localparam logic [3:0]  FIXED_BYTES = 4'd10;
	localparam logic [3:0]  ADDR_BYTES  = 4'd4;
	localparam logic [7:0]  PTR_MASK    = 8'hC0;

	// Parser phases, one-hot.
	typedef enum logic [10:0] {
		PH_HDR    = 11'b00000000001,
		PH_QLEN   = 11'b00000000010,
		PH_QSKIP  = 11'b00000000100,
		PH_QFIX   = 11'b00000001000,
		PH_ANAME  = 11'b00000010000,
		PH_ASCAN  = 11'b00000100000,
		PH_APTR   = 11'b00001000000,
		PH_FIXED  = 11'b00010000000,
		PH_RDATA  = 11'b00100000000,
		PH_SKIPRD = 11'b01000000000,
		PH_DONE   = 11'b10000000000
	} phase_t;

endpackage

// ----- sv/dnsar_cfg.sv -----
// Configuration register file holding the expected transaction id.
module dnsar_cfg import dnsar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] expected_id
);

	logic [15:0] expected_id_q;
	logic        sel_id;

	// Word address decode: only the first word holds a register.
	assign sel_id = (paddr[2] == REG_EXPECTED_ID);

	// Register write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= '0;
		end else if (psel && penable && pwrite && sel_id) begin
			expected_id_q <= pwdata[15:0];
		end
	end

	// Read data and ready.
	assign prdata      = sel_id ? {16'd0, expected_id_q} : 32'd0;
	assign pready      = 1'b1;
	assign expected_id = expected_id_q;

endmodule

// ----- sv/dnsar_parser.sv -----
// Byte-serial DNS response parser: one state update per accepted byte.
module dnsar_parser import dnsar_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_item_t    item,
	input  logic [15:0] expected_id,
	output logic        emit,
	output out_item_t   result
);

	localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);

	logic [PosW-1:0] pos_q, pos_nx;
	phase_t          phase_q, phase_nx;
	logic [15:0]     answers_q, answers_nx;
	logic [15:0]     skip_q, skip_nx;
	logic [3:0]      shift_q, shift_nx;
	logic [31:0]     accum_q, accum_nx;
	logic            found_q, found_nx;
	logic            idm_q, idm_nx;

	// Next packet state for the byte at the input.
	always_comb begin
		logic [7:0]  b;
		logic [15:0] ans_dec;
		logic [15:0] skip_dec;
		logic [3:0]  shift_inc;
		logic [31:0] fix_type;
		logic [15:0] fix_len;

		b          = item.data_byte;
		ans_dec    = answers_q - 16'd1;
		skip_dec   = skip_q - 16'd1;
		shift_inc  = shift_q + 4'd1;
		fix_type   = accum_q;
		fix_len    = skip_q;

		pos_nx     = pos_q;
		phase_nx   = phase_q;
		answers_nx = answers_q;
		skip_nx    = skip_q;
		shift_nx   = shift_q;
		accum_nx   = accum_q;
		found_nx   = found_q;
		idm_nx     = idm_q;

		// Bytes past the size limit leave the state alone.
		if (pos_q != PosW'(MAX_PACKET_BYTES)) begin
			pos_nx = pos_q + PosW'(1);
			unique case (phase_q)
				PH_HDR: begin
					if (pos_q == PosW'(0)) begin
						idm_nx = (b == expected_id[7:0]);
					end else if (pos_q == PosW'(1)) begin
						idm_nx = idm_q & (b == expected_id[15:8]);
					end else if (pos_q == PosW'(6)) begin
						answers_nx = {b, 8'd0};
					end else if (pos_q == PosW'(7)) begin
						answers_nx = answers_q | {8'd0, b};
					end
					if (pos_q == PosW'(HDR_BYTES - 1)) begin
						phase_nx = (answers_q == 16'd0) ? PH_DONE : PH_QLEN;
					end
				end
				PH_QLEN: begin
					if (b == 8'd0) begin
						skip_nx  = 16'd4;
						phase_nx = PH_QFIX;
					end else if ((b & PTR_MASK) == PTR_MASK) begin
						skip_nx  = 16'd5;
						phase_nx = PH_QFIX;
					end else begin
						skip_nx  = {8'd0, b};
						phase_nx = PH_QSKIP;
					end
				end
				PH_QSKIP: begin
					skip_nx = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_nx = PH_QLEN;
					end
				end
				PH_QFIX: begin
					skip_nx = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_nx = PH_ANAME;
					end
				end
				PH_ANAME: begin
					shift_nx = 4'd0;
					accum_nx = 32'd0;
					if ((b & PTR_MASK) == PTR_MASK) begin
						phase_nx = PH_APTR;
					end else if (b == 8'd0) begin
						phase_nx = PH_FIXED;
					end else begin
						phase_nx = PH_ASCAN;
					end
				end
				PH_ASCAN: begin
					if (b == 8'd0) begin
						phase_nx = PH_FIXED;
					end
				end
				PH_APTR: begin
					phase_nx = PH_FIXED;
				end
				PH_FIXED: begin
					// The accumulator holds the record type, the skip count the rdlen.
					if (shift_q == 4'd0) begin
						fix_type = {16'd0, b, 8'd0};
					end else if (shift_q == 4'd1) begin
						fix_type = accum_q | {24'd0, b};
					end else if (shift_q == 4'd8) begin
						fix_len = {b, 8'd0};
					end else if (shift_q == 4'd9) begin
						fix_len = skip_q | {8'd0, b};
					end
					accum_nx = fix_type;
					skip_nx  = fix_len;
					shift_nx = shift_inc;
					if (shift_inc == FIXED_BYTES) begin
						shift_nx = 4'd0;
						if (fix_type == 32'd1 && fix_len == {12'd0, ADDR_BYTES}) begin
							accum_nx = 32'd0;
							phase_nx = PH_RDATA;
						end else if (fix_len == 16'd0) begin
							answers_nx = ans_dec;
							phase_nx   = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
						end else begin
							phase_nx = PH_SKIPRD;
						end
					end
				end
				PH_RDATA: begin
					accum_nx = {accum_q[23:0], b};
					shift_nx = shift_inc;
					if (shift_inc == ADDR_BYTES) begin
						found_nx = 1'b1;
						phase_nx = PH_DONE;
					end
				end
				PH_SKIPRD: begin
					skip_nx = skip_dec;
					if (skip_dec == 16'd0) begin
						answers_nx = ans_dec;
						phase_nx   = (ans_dec == 16'd0) ? PH_DONE : PH_ANAME;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Result for a packet that ends with this byte.
	always_comb begin
		result.address = 32'd0;
		if (pos_nx < PosW'(HDR_BYTES)) begin
			result.status = ST_SHORT;
		end else if (!idm_nx) begin
			result.status = ST_MISMATCH;
		end else if (found_nx && accum_nx != 32'd0) begin
			result.status  = ST_FOUND;
			result.address = accum_nx;
		end else begin
			result.status = ST_NO_A;
		end
	end

	assign emit = accept && item.last_byte;

	// Packet state: advance per byte, back to reset after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			phase_q   <= PH_HDR;
			answers_q <= '0;
			skip_q    <= '0;
			shift_q   <= '0;
			accum_q   <= '0;
			found_q   <= 1'b0;
			idm_q     <= 1'b1;
		end else if (accept) begin
			if (item.last_byte) begin
				pos_q     <= '0;
				phase_q   <= PH_HDR;
				answers_q <= '0;
				skip_q    <= '0;
				shift_q   <= '0;
				accum_q   <= '0;
				found_q   <= 1'b0;
				idm_q     <= 1'b1;
			end else begin
				pos_q     <= pos_nx;
				phase_q   <= phase_nx;
				answers_q <= answers_nx;
				skip_q    <= skip_nx;
				shift_q   <= shift_nx;
				accum_q   <= accum_nx;
				found_q   <= found_nx;
				idm_q     <= idm_nx;
			end
		end
	end

endmodule

// ----- sv/dnsar_out_reg.sv -----
// Result register that holds one item until the receiver takes it.
module dnsar_out_reg import dnsar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_item,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_item,
	output logic      full_stalled
);

	logic      valid_q;
	out_item_t item_q;

	// Load a new result, or drop the held one once it has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= load_item;
		end
	end

	assign out_valid    = valid_q;
	assign out_item     = item_q;
	assign full_stalled = valid_q && out_stall;

endmodule

// ----- sv/dns_response_a_record_parser_top.sv -----
// Top level of the DNS response A-record parser.
//
// The input channel carries one packet byte per item with a last-byte marker;
// the output channel carries one status and IPv4 address per packet.
// Bytes 0 and 1 must match the expected_id register (low byte first), the
// answer count comes from bytes 6 and 7, and the first type-1 record with a
// four-byte rdata is captured.
// Throughput is one byte per cycle while in_stall is low: each byte is one
// update of the packet state registers. The result appears on out_valid in
// the cycle after the last byte is accepted, from the output result register.
// While a result waits under out_stall, bytes keep flowing; only a next
// last byte is held off (in_stall) until the waiting result is taken.
// Reset clears the packet state and the expected id and empties the result
// register. The user must write expected_id over the APB port only while no
// packet is in flight; the block does not enforce this. pready is always high.
module dns_response_a_record_parser_top import dnsar_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] expected_id;
	logic        accept;
	logic        emit;
	out_item_t   result;
	logic        full_stalled;

	// Only a packet's last byte needs a free result slot.
	assign in_stall = full_stalled && in_item.last_byte;
	assign accept   = in_valid && !in_stall;

	dnsar_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.expected_id (expected_id)
	);

	dnsar_parser #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (in_item),
		.expected_id (expected_id),
		.emit        (emit),
		.result      (result)
	);

	dnsar_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (emit),
		.load_item    (result),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_item     (out_item),
		.full_stalled (full_stalled)
	);

endmodule

// ----- sv/dnsar_checker.sv -----
// Port-level checker for the DNS response A-record parser, bound to the top level.
module dnsar_checker import dnsar_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A held result stays put while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or vanished");

	// An accepted last byte gives a result in the next cycle.
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.last_byte |=> out_valid)
		else $error("last byte accepted without a result");

	// Input stalls only for a last byte facing a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && in_item.last_byte)
		else $error("input stalled without a waiting result");

	// Address is zero unless found, and nonzero when found.
	a_addr_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.status == ST_FOUND) == (out_item.address != 32'd0)))
		else $error("address does not agree with status");

endmodule

bind dns_response_a_record_parser_top dnsar_checker u_dnsar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ----- dv/tb_top.sv -----
// Testbench for the DNS response A-record parser: directed and random packets checked per item.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dnsar_pkg::*;

	localparam int MAX_BYTES   = 512;
	localparam int GAP_MAX     = 17;
	localparam int HOLD_CYCLES = 400;
	localparam int QTAIL_BYTES = 4;

	localparam logic [15:0] TYPE_A     = 16'd1;
	localparam logic [15:0] TYPE_CNAME = 16'd5;
	localparam logic [15:0] TYPE_AAAA  = 16'd28;

	// Shapes of the question name and of an answer name.
	typedef enum int {QN_LABELS, QN_PTR, QN_WIDE} qname_e;
	typedef enum int {NM_PTR, NM_LABELS, NM_ROOT} rname_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	dns_response_a_record_parser_top #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	in_item_t    byte_feed[$];
	out_item_t   due_replies[$];
	logic [7:0]  pkt_bytes[$];
	int          bytes_sent = 0;
	int          fail_cnt = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          tx_gap_max = GAP_MAX;
	int          rx_gap_max = GAP_MAX;
	int          hold_left = 0;
	bit          hold_req = 1'b0;
	bit          in_acc = 1'b0;
	bit          out_acc = 1'b0;
	bit          stall_now;

	// Parser state as the block should hold it.
	logic [15:0] cfg_id = '0;
	logic [9:0]  pos;
	phase_t      ph;
	logic [15:0] ans_left;
	logic [15:0] skip_left;
	logic [15:0] fld_idx;
	logic [31:0] acc;
	logic        got_addr;
	logic        id_ok;

	function automatic void clear_packet();
		pos = '0;
		ph = PH_HDR;
		ans_left = '0;
		skip_left = '0;
		fld_idx = '0;
		acc = '0;
		got_addr = 1'b0;
		id_ok = 1'b1;
	endfunction

	function automatic void count_down_answers();
		ans_left = ans_left - 16'd1;
		ph = (ans_left == 16'd0) ? PH_DONE : PH_ANAME;
	endfunction

	// One byte of parsing: walks header, question, and answer records.
	function automatic void model_parse_byte(logic [7:0] b);
		case (ph)
			PH_HDR: begin
				if (pos == 0)
					id_ok = (b == cfg_id[7:0]);
				else if (pos == 1)
					id_ok = id_ok & (b == cfg_id[15:8]);
				else if (pos == 6)
					ans_left = {b, 8'h00};
				else if (pos == 7)
					ans_left = ans_left | {8'h00, b};
				if (pos == HDR_BYTES - 1)
					ph = (ans_left == 16'd0) ? PH_DONE : PH_QLEN;
			end
			PH_QLEN: begin
				if (b == 8'h00) begin
					skip_left = 16'(QTAIL_BYTES);
					ph = PH_QFIX;
				end else if ((b & PTR_MASK) == PTR_MASK) begin
					// The pointer's second byte comes before type and class.
					skip_left = 16'(QTAIL_BYTES + 1);
					ph = PH_QFIX;
				end else begin
					skip_left = {8'h00, b};
					ph = PH_QSKIP;
				end
			end
			PH_QSKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					ph = PH_QLEN;
			end
			PH_QFIX: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					ph = PH_ANAME;
			end
			PH_ANAME: begin
				fld_idx = '0;
				acc = '0;
				if ((b & PTR_MASK) == PTR_MASK)
					ph = PH_APTR;
				else if (b == 8'h00)
					ph = PH_FIXED;
				else
					ph = PH_ASCAN;
			end
			PH_ASCAN: begin
				if (b == 8'h00)
					ph = PH_FIXED;
			end
			PH_APTR: begin
				ph = PH_FIXED;
			end
			PH_FIXED: begin
				// The accumulator holds the record type, skip_left the rdlen.
				if (fld_idx == 16'd0)
					acc = {16'h0000, b, 8'h00};
				else if (fld_idx == 16'd1)
					acc = acc | {24'h0, b};
				else if (fld_idx == 16'd8)
					skip_left = {b, 8'h00};
				else if (fld_idx == 16'd9)
					skip_left = skip_left | {8'h00, b};
				fld_idx = fld_idx + 16'd1;
				if (fld_idx == 16'(FIXED_BYTES)) begin
					fld_idx = '0;
					if (acc == 32'd1 && skip_left == 16'(ADDR_BYTES)) begin
						acc = '0;
						ph = PH_RDATA;
					end else if (skip_left == 16'd0) begin
						count_down_answers();
					end else begin
						ph = PH_SKIPRD;
					end
				end
			end
			PH_RDATA: begin
				acc = {acc[23:0], b};
				fld_idx = fld_idx + 16'd1;
				if (fld_idx == 16'(ADDR_BYTES)) begin
					got_addr = 1'b1;
					ph = PH_DONE;
				end
			end
			PH_SKIPRD: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					count_down_answers();
			end
			default: ;
		endcase
	endfunction

	// Parses an accepted byte and queues the reply that a last byte causes.
	function automatic void predict_reply(in_item_t it);
		out_item_t r;
		if (pos < MAX_BYTES) begin
			model_parse_byte(it.data_byte);
			pos = pos + 10'd1;
		end
		if (it.last_byte) begin
			r.address = '0;
			if (pos < HDR_BYTES) begin
				r.status = ST_SHORT;
			end else if (!id_ok) begin
				r.status = ST_MISMATCH;
			end else if (got_addr && acc != 32'd0) begin
				r.status = ST_FOUND;
				r.address = acc;
			end else begin
				r.status = ST_NO_A;
			end
			due_replies.push_back(r);
			clear_packet();
		end
	endfunction

	function automatic void note_fail(string what, out_item_t want, out_item_t got);
		if (fail_cnt < 10)
			$display("%0t %s: expected status %0d address %h, got status %0d address %h",
				$realtime, what, want.status, want.address, got.status, got.address);
		fail_cnt++;
	endfunction

	// Packet building.
	function automatic void put_rand(int n);
		repeat (n) pkt_bytes.push_back(8'($urandom));
	endfunction

	function automatic void put_header(logic [15:0] id, logic [15:0] ancount);
		pkt_bytes.push_back(id[7:0]);
		pkt_bytes.push_back(id[15:8]);
		put_rand(4);
		pkt_bytes.push_back(ancount[15:8]);
		pkt_bytes.push_back(ancount[7:0]);
		put_rand(4);
	endfunction

	function automatic void put_question(qname_e kind);
		int nlab;
		int len;
		case (kind)
			QN_PTR: begin
				pkt_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
				put_rand(1 + QTAIL_BYTES);
			end
			QN_WIDE: begin
				len = $urandom_range(8'h40, 8'hBF);
				pkt_bytes.push_back(8'(len));
				put_rand(len);
				pkt_bytes.push_back(8'h00);
				put_rand(QTAIL_BYTES);
			end
			default: begin
				nlab = $urandom_range(1, 3);
				for (int i = 0; i < nlab; i++) begin
					len = $urandom_range(1, 12);
					pkt_bytes.push_back(8'(len));
					put_rand(len);
				end
				pkt_bytes.push_back(8'h00);
				put_rand(QTAIL_BYTES);
			end
		endcase
	endfunction

	function automatic void put_record(rname_e nk, logic [15:0] rtype, logic [15:0] rdlen,
			logic [31:0] addr);
		int n;
		case (nk)
			NM_PTR: begin
				pkt_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
				put_rand(1);
			end
			NM_LABELS: begin
				// Scanned names must hold no zero before their terminator.
				n = $urandom_range(1, 8);
				pkt_bytes.push_back(8'($urandom_range(1, 8'hBF)));
				repeat (n - 1) pkt_bytes.push_back(8'($urandom_range(1, 255)));
				pkt_bytes.push_back(8'h00);
			end
			default: pkt_bytes.push_back(8'h00);
		endcase
		pkt_bytes.push_back(rtype[15:8]);
		pkt_bytes.push_back(rtype[7:0]);
		put_rand(6);
		pkt_bytes.push_back(rdlen[15:8]);
		pkt_bytes.push_back(rdlen[7:0]);
		if (rtype == TYPE_A && rdlen == 16'(ADDR_BYTES)) begin
			pkt_bytes.push_back(addr[31:24]);
			pkt_bytes.push_back(addr[23:16]);
			pkt_bytes.push_back(addr[15:8]);
			pkt_bytes.push_back(addr[7:0]);
		end else begin
			put_rand(rdlen);
		end
	endfunction

	// Moves the built packet to the driver, cut to keep bytes when keep is set.
	function automatic void send_packet(int keep);
		int n;
		in_item_t it;
		n = (keep > 0 && keep < pkt_bytes.size()) ? keep : pkt_bytes.size();
		for (int i = 0; i < n; i++) begin
			it.data_byte = pkt_bytes[i];
			it.last_byte = (i == n - 1);
			byte_feed.push_back(it);
		end
		bytes_sent += n;
		pkt_bytes.delete();
	endfunction

	// Mostly well-formed replies, with noise, wrong ids and cut packets mixed in.
	function automatic void random_packet();
		int kind;
		int n_ans;
		int r;
		int q;
		rname_e nk;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			put_rand($urandom_range(1, 40));
			send_packet(0);
			return;
		end
		n_ans = $urandom_range(1, 3);
		put_header((kind == 1) ? cfg_id ^ 16'($urandom_range(1, 16'hFFFF)) : cfg_id,
			($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 5)) : 16'(n_ans));
		q = $urandom_range(0, 9);
		put_question((q == 0) ? QN_WIDE : (q < 4) ? QN_PTR : QN_LABELS);
		for (int i = 0; i < n_ans; i++) begin
			r = $urandom_range(0, 5);
			nk = rname_e'($urandom_range(0, 2));
			case (r)
				0, 1, 2: put_record(nk, TYPE_A, 16'(ADDR_BYTES),
					($urandom_range(0, 15) == 0) ? 32'h0 : 32'($urandom));
				3: put_record(nk, r[0] ? TYPE_CNAME : TYPE_AAAA, 16'($urandom_range(0, 20)), '0);
				4: put_record(nk, TYPE_A, 16'($urandom_range(0, 8)), 32'($urandom));
				default: put_record(nk, 16'($urandom), 16'($urandom_range(0, 12)), 32'($urandom));
			endcase
		end
		put_rand($urandom_range(0, 3));
		send_packet((kind == 2) ? $urandom_range(1, pkt_bytes.size()) : 0);
	endfunction

	task automatic write_id(logic [15:0] id);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * int'(REG_EXPECTED_ID));
		pwdata <= {16'h0000, id};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_id = id;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every byte is taken and every reply has come back.
	task automatic wait_idle();
		while (byte_feed.size() != 0 || in_valid || due_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Input side: predict on every accepted item.
	always @(posedge clk) begin
		in_acc = arst_n && in_valid && !in_stall;
		if (in_acc)
			predict_reply(in_item);
	end

	// Output side: compare each accepted result with the oldest reply due.
	always @(posedge clk) begin
		out_acc = arst_n && out_valid && !out_stall;
		if (out_acc) begin
			if (due_replies.size() == 0) begin
				note_fail("unexpected result", '0, out_item);
			end else begin
				if (out_item.status !== due_replies[0].status ||
						out_item.address !== due_replies[0].address)
					note_fail("mismatch", due_replies[0], out_item);
				void'(due_replies.pop_front());
			end
		end
	end

	// Long receiver hold-off, counted in cycles.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	// Driver: one item from the feed, with a random wait after each accepted item.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc)
				tx_gap = $urandom_range(0, tx_gap_max);
			if (!in_valid || in_acc) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (byte_feed.size() != 0) begin
					in_item <= byte_feed.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall after each result, plus the long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_acc)
				rx_gap = $urandom_range(0, rx_gap_max);
			stall_now = (hold_left > 0);
			if (rx_gap > 0) begin
				stall_now = 1'b1;
				rx_gap--;
			end
			out_stall <= stall_now;
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		clear_packet();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The id register comes out of reset as zero.
		put_header(16'h0000, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'hC0A8_0101);
		send_packet(0);
		wait_idle();

		write_id(16'hFFFF);
		// Packets shorter than the header, one of them with a wrong id as well.
		put_rand(1);
		send_packet(0);
		put_header(16'hFFFF, 16'd1);
		send_packet(HDR_BYTES - 1);
		put_header(16'h1234, 16'd1);
		send_packet(3);
		// Zero answer count, bare and with trailing bytes.
		put_header(16'hFFFF, 16'd0);
		send_packet(0);
		put_header(16'hFFFF, 16'd0);
		put_rand(5);
		send_packet(0);
		// Wrong low id byte, then wrong high id byte, both with an A record.
		put_header(16'hFF7F, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0102_0304);
		send_packet(0);
		put_header(16'h7FFF, 16'd1);
		put_question(QN_PTR);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0102_0304);
		send_packet(0);
		// Found, with pointer question and scanned answer name.
		put_header(16'hFFFF, 16'd1);
		put_question(QN_PTR);
		put_record(NM_LABELS, TYPE_A, 16'(ADDR_BYTES), 32'hFFFF_FFFF);
		send_packet(0);
		// Root-name CNAME skipped before the A record.
		put_header(16'hFFFF, 16'd2);
		put_question(QN_LABELS);
		put_record(NM_ROOT, TYPE_CNAME, 16'd6, '0);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0000_0001);
		send_packet(0);
		// All-zero address counts as not found.
		put_header(16'hFFFF, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0);
		send_packet(0);
		// Packet ends inside the address bytes.
		put_header(16'hFFFF, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0A0B_0C0D);
		send_packet(pkt_bytes.size() - 2);
		// Label length between 0x40 and 0xBF is a plain length.
		put_header(16'hFFFF, 16'd1);
		put_question(QN_WIDE);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h8000_0000);
		send_packet(0);
		// Records after a capture are ignored.
		put_header(16'hFFFF, 16'd3);
		put_question(QN_PTR);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0A00_0001);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0A00_0002);
		put_record(NM_ROOT, TYPE_CNAME, 16'd3, '0);
		send_packet(0);
		// Type 1 with the wrong rdlen and an empty record are skipped.
		put_header(16'hFFFF, 16'd3);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'd6, '0);
		put_record(NM_ROOT, TYPE_AAAA, 16'd0, '0);
		put_record(NM_LABELS, TYPE_A, 16'(ADDR_BYTES), 32'h7F00_0001);
		send_packet(0);
		// Largest answer count; then an A record beyond the answer count.
		put_header(16'hFFFF, 16'hFFFF);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'hDEAD_BEEF);
		send_packet(0);
		put_header(16'hFFFF, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_CNAME, 16'd2, '0);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'h0505_0505);
		send_packet(0);
		// Oversize packets: capture before the size limit, and an A record past it.
		put_header(16'hFFFF, 16'd1);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'hC633_6401);
		put_rand(540 - pkt_bytes.size());
		send_packet(0);
		put_header(16'hFFFF, 16'd2);
		put_question(QN_LABELS);
		put_record(NM_PTR, TYPE_CNAME, 16'd500, '0);
		put_record(NM_PTR, TYPE_A, 16'(ADDR_BYTES), 32'hC633_6402);
		send_packet(0);
		wait_idle();

		// Random packets under several ids and idle patterns.
		for (int ph_i = 0; ph_i < 4; ph_i++) begin
			int target;
			write_id((ph_i == 0) ? 16'h0000 : (ph_i == 2) ? 16'hFFFF : 16'($urandom));
			tx_gap_max = ph_i[0] ? 0 : GAP_MAX;
			rx_gap_max = (ph_i == 2) ? 0 : GAP_MAX;
			target = bytes_sent + 75;
			while (bytes_sent < target)
				random_packet();
			wait_idle();
		end

		// Back-to-back short packets while the receiver holds off.
		write_id(16'($urandom));
		tx_gap_max = 0;
		rx_gap_max = GAP_MAX;
		@(negedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++) begin
			if (i % 4 == 3) begin
				put_rand(1);
			end else begin
				put_header(cfg_id, 16'd0);
				put_rand(1);
			end
			send_packet(0);
		end
		wait_idle();

		repeat (8) @(negedge clk);
		if (due_replies.size() != 0)
			note_fail("result missing", due_replies[0], '0);
		if (fail_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/dnsar_pkg.sv
sv/dnsar_cfg.sv
sv/dnsar_parser.sv
sv/dnsar_out_reg.sv
sv/dns_response_a_record_parser_top.sv
sv/dnsar_checker.sv
dv/tb_top.sv
